// ----- rtl/core/ems_pkg.sv -----
// Shared types and constants for the echo melody sample synthesizer.
// Holds the melody frequency table and the tap spacing. No dependencies.
package ems_pkg;

    localparam int unsigned TIdxW   = 16;
    localparam int unsigned SampW   = 8;
    localparam int unsigned NTaps   = 4;
    localparam logic [7:0]  RScale  = 8'd213;
    localparam logic [16:0] TapSpacing = 17'd12288;
    localparam logic [7:0]  SignFlip = 8'h80;
    localparam logic [8:0]  SumMax  = 9'd240;

    typedef logic [TIdxW-1:0] tidx_t;
    typedef logic [SampW-1:0] samp_t;
    typedef logic [7:0]       freq_t;

    // Melody string decoded through the frequency table, one entry per note slot.
    function automatic freq_t note_freq(input logic [4:0] idx);
        freq_t f;
        unique case (idx)
            5'd0:  f = 8'd81;   5'd1:  f = 8'd81;   5'd2:  f = 8'd96;   5'd3:  f = 8'd81;
            5'd4:  f = 8'd108;  5'd5:  f = 8'd81;   5'd6:  f = 8'd121;  5'd7:  f = 8'd108;
            5'd8:  f = 8'd96;   5'd9:  f = 8'd96;   5'd10: f = 8'd121;  5'd11: f = 8'd96;
            5'd12: f = 8'd144;  5'd13: f = 8'd96;   5'd14: f = 8'd121;  5'd15: f = 8'd96;
            5'd16: f = 8'd72;   5'd17: f = 8'd72;   5'd18: f = 8'd90;   5'd19: f = 8'd72;
            5'd20: f = 8'd96;   5'd21: f = 8'd72;   5'd22: f = 8'd108;  5'd23: f = 8'd96;
            5'd24: f = 8'd64;   5'd25: f = 8'd64;   5'd26: f = 8'd81;   5'd27: f = 8'd64;
            5'd28: f = 8'd96;   5'd29: f = 8'd64;   5'd30: f = 8'd96;   5'd31: f = 8'd90;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/core/ems_tap.sv -----
// One voice tap of the echo synthesizer: position, note lookup, sawtooth,
// gate and envelope over three register stages. Uses ems_pkg.
module ems_tap #(
    parameter int unsigned TAP_IDX = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  ems_pkg::tidx_t t_in,
    input  ems_pkg::tidx_t r_in,
    output ems_pkg::samp_t tap_out
);

    localparam logic [16:0] Back = 17'(TAP_IDX) * ems_pkg::TapSpacing;

    // stage A: position and note frequency
    logic [16:0]    diff;
    logic           neg_a_reg, neg_a_next;
    logic [15:0]    pos_a_reg, pos_a_next;
    ems_pkg::tidx_t t_a_reg;
    ems_pkg::freq_t freq_a_reg, freq_a_next;

    assign diff       = {1'b0, r_in} - Back;
    assign neg_a_next = diff[16];
    assign pos_a_next = diff[15:0];
    assign freq_a_next = ems_pkg::note_freq({2'b00, pos_a_next[15:13]});

    // stage B: sawtooth, sub-position and envelope
    logic [23:0] saw_prod;
    logic [6:0]  saw_b_reg, saw_b_next;
    logic [6:0]  sub_b_reg;
    logic [13:0] env_full;
    logic [7:0]  env_b_reg, env_b_next;
    logic        neg_b_reg;

    assign saw_prod   = 24'(t_a_reg) * 24'(freq_a_reg);
    assign saw_b_next = saw_prod[13:7];
    assign env_full   = 14'd8192 - {1'b0, pos_a_reg[12:0]};
    assign env_b_next = env_full[13:6];

    // stage C: gate
    logic [7:0]     gate_sum;
    ems_pkg::samp_t tap_c_reg, tap_c_next;

    assign gate_sum   = {1'b0, saw_b_reg} + {1'b0, sub_b_reg};
    assign tap_c_next = (neg_b_reg || !gate_sum[7]) ? '0 : env_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_a_reg  <= neg_a_next;
            pos_a_reg  <= pos_a_next;
            t_a_reg    <= t_in;
            freq_a_reg <= freq_a_next;
            saw_b_reg  <= saw_b_next;
            sub_b_reg  <= pos_a_reg[12:6];
            env_b_reg  <= env_b_next;
            neg_b_reg  <= neg_a_reg;
            tap_c_reg  <= tap_c_next;
        end
    end

    assign tap_out = tap_c_reg;

endmodule

// ----- rtl/core/echo_melody_sample_synth_core.sv -----
// Top level of the echo melody sample synthesizer: scaling stage, four
// tap pipelines, weighted sum and output register. Uses ems_pkg, ems_tap.
//
// Usage: each item on the s_ channel is a 16-bit sample index t; each item
// on the m_ channel is the matching 8-bit offset-binary sample, in order.
// Exactly one result per input item, no configuration.
// Registered stages from acceptance to m_tvalid: scale, position/note,
// sawtooth/envelope, gate, sum. Throughput: one item per cycle unless the
// receiver stalls; the longest path is one 16x8 multiply (scale, sawtooth).
// The whole pipeline moves on one enable; it advances whenever the output
// register is empty or being taken, so s_tready stays high while a result
// is waiting as long as m_tready is high or the output slot is free.
// When the receiver stalls with a result held, every stage freezes and
// s_tready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; m_tvalid is low
// in the cycle after reset.
module echo_melody_sample_synth_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] sample_value
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // valid bits: stage 1 (scale), 2..4 (taps), output
    logic [3:0] vld_reg, vld_next;
    logic       out_vld_reg;

    assign vld_next = {vld_reg[2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[3];
        end
    end

    // stage 1: song position r = (t * 213) >> 8
    logic [23:0]     r_prod;
    ems_pkg::tidx_t  t1_reg;
    ems_pkg::tidx_t  r1_reg, r1_next;

    assign r_prod  = 24'(s_tdata) * 24'(ems_pkg::RScale);
    assign r1_next = r_prod[23:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= s_tdata;
            r1_reg <= r1_next;
        end
    end

    ems_pkg::samp_t tap_val [ems_pkg::NTaps];

    for (genvar gi = 0; gi < ems_pkg::NTaps; gi++) begin : g_tap
        ems_tap #(.TAP_IDX(gi)) u_tap (
            .aclk    (aclk),
            .en      (en),
            .t_in    (t1_reg),
            .r_in    (r1_reg),
            .tap_out (tap_val[gi])
        );
    end

    // weighted sum, at most 240, then flip the top bit
    logic [8:0]     sum;
    ems_pkg::samp_t out_reg, out_next;

    assign sum = {1'b0, tap_val[0]}
               + {2'b00, tap_val[1][7:1]}
               + {3'b000, tap_val[2][7:2]}
               + {4'b0000, tap_val[3][7:3]};
    assign out_next = sum[7:0] ^ ems_pkg::SignFlip;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // the tap sum never exceeds its bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (sum <= ems_pkg::SumMax))
        else $error("tap sum out of range");

    // an item in the last tap stage reaches the output when the pipe moves
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[3] && en) |=> m_tvalid)
        else $error("item dropped before output");

    // a frozen pipe keeps its valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
